// ===== rtl/twclk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Package for the twelve hour clock controller: mode codes, reset values,
// the time-of-day type and the rollover function. Depends on nothing.
package twclk_pkg;

   localparam int TPM_WIDTH = 16;

   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_RUN   = 2'd1;
   localparam logic [1:0] MODE_PEND  = 2'd2;
   localparam logic [1:0] MODE_LOWP  = 2'd3;

   localparam logic [TPM_WIDTH-1:0] TPM_RESET  = 16'd240;
   localparam logic [TPM_WIDTH-1:0] TICK_MAX   = 16'hFFFF;
   localparam logic [5:0]           MINUTE_TOP = 6'd60;
   localparam logic [3:0]           HOUR_TOP   = 4'd13;
   localparam logic [3:0]           HOUR_SPAN  = 4'd12;
   localparam logic [3:0]           HOUR_NOON  = 4'd12;
   localparam logic [1:0]           PHASE_LAST = 2'd3;
   localparam logic [1:0]           PHASE_INIT = 2'd1;

   typedef struct packed {
      logic [5:0] minute;
      logic [3:0] hour;
      logic       pm;
   } time_type;

   // Carry minute 60 into the hour, then hour 13 into the AM/PM flag.
   function automatic time_type roll_time(input time_type t);
      time_type r;
      r = t;
      if (r.minute >= MINUTE_TOP) begin
         r.minute = r.minute - MINUTE_TOP;
         r.hour   = r.hour + 4'd1;
      end
      if (r.hour >= HOUR_TOP) begin
         r.hour = r.hour - HOUR_SPAN;
         r.pm   = ~r.pm;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/twclk_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Request channel of the twelve hour clock controller: one timer tick with
// the button and power inputs. Stands alone.
interface twclk_req_if;
   logic valid;
   logic ready;
   logic set_none_pressed;
   logic minute_pressed;
   logic hour_pressed;
   logic power_good;

   modport source (
      output valid, set_none_pressed, minute_pressed, hour_pressed, power_good,
      input  ready
   );
   modport sink (
      input  valid, set_none_pressed, minute_pressed, hour_pressed, power_good,
      output ready
   );
endinterface
`default_nettype wire

// ===== rtl/twclk_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Response channel of the twelve hour clock controller: time, display and
// mode after one tick. Stands alone.
interface twclk_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] minute_value;
   logic [3:0] hour_value;
   logic       pm_flag;
   logic       display_lit;
   logic       tick_lamp;
   logic [1:0] mode_now;

   modport source (
      output valid, minute_value, hour_value, pm_flag, display_lit, tick_lamp,
             mode_now,
      input  ready
   );
   modport sink (
      input  valid, minute_value, hour_value, pm_flag, display_lit, tick_lamp,
             mode_now,
      output ready
   );
endinterface
`default_nettype wire

// ===== rtl/twelve_hour_clock_controller_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Twelve hour clock controller, top level.
// Uses twclk_pkg and the interfaces twclk_req_if and twclk_rsp_if.
//
// Usage:
//   req_chan carries one timer tick per request: the three set buttons and
//   the power-good input. rsp_chan returns exactly one response per request:
//   minute, hour, AM/PM, display lit, tick lamp and the current mode, all as
//   they stand after the tick. csr_wr_en/csr_wr_data write ticks_per_minute;
//   write it only while no request is in flight.
//   The request lands in the input register at the accepting edge; one pass
//   of compares and adds then updates the clock state and loads the result
//   register, which raises rsp_chan.valid, but only once that register is
//   free or being read. Throughput is one request per cycle while responses
//   are taken; the two registers are separate, so a request is still taken
//   while a response waits, and only when both are full does req_chan.ready drop.
//   Reset (synchronous, active high) empties both registers and puts the
//   clock in start mode showing 12:00 PM, blink phase 1, tick period 240.
//   A stalled receiver holds the response steady; nothing is dropped.
module twelve_hour_clock_controller_unit
   import twclk_pkg::*;
(
   input  wire                  clock,
   input  wire                  reset,
   twclk_req_if.sink            req_chan,
   twclk_rsp_if.source          rsp_chan,
   input  wire                  csr_wr_en,
   input  wire [TPM_WIDTH-1:0]  csr_wr_data
);

   // Configuration register
   logic [TPM_WIDTH-1:0] tpm_ff;

   // Input register
   logic in_valid_ff;
   logic in_set_none_ff, in_minute_ff, in_hour_ff, in_power_ff;

   // Clock state
   logic [1:0]           mode_ff,  mode_in;
   logic [TPM_WIDTH-1:0] count_ff, count_in;
   time_type             time_ff,  time_in;
   logic [1:0]           phase_ff, phase_in;
   logic                 lamp_ff,  lamp_in;
   logic                 lit_ff,   lit_in;

   // Result register
   logic       out_valid_ff;
   time_type   out_time_ff;
   logic       out_lit_ff, out_lamp_ff;
   logic [1:0] out_mode_ff;

   logic                 advance;
   logic                 any_pressed;
   logic [TPM_WIDTH-1:0] count_inc;
   logic                 minute_due;
   time_type             time_plus_minute;
   time_type             time_plus_hour;

   // Move the held request into the result register when that is free or
   // being emptied this cycle; take a new request whenever the input
   // register will be free.
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   assign any_pressed = in_set_none_ff || in_minute_ff || in_hour_ff;

   always_comb begin
      // Count rises once per tick and sticks at the ceiling.
      if (count_ff != TICK_MAX) begin
         count_inc = count_ff + 16'd1;
      end else begin
         count_inc = count_ff;
      end
      minute_due = (count_inc >= tpm_ff);

      time_plus_minute        = time_ff;
      time_plus_minute.minute = time_ff.minute + 6'd1;
      time_plus_minute        = roll_time(time_plus_minute);
      time_plus_hour          = time_ff;
      time_plus_hour.hour     = time_ff.hour + 4'd1;
      time_plus_hour          = roll_time(time_plus_hour);

      mode_in  = mode_ff;
      count_in = count_inc;
      time_in  = time_ff;
      phase_in = phase_ff;
      lamp_in  = lamp_ff;
      lit_in   = lit_ff;

      // Power loss overrides every mode and drops a pending press.
      if (!in_power_ff && mode_ff != MODE_LOWP) begin
         mode_in = MODE_LOWP;
         lit_in  = 1'b0;
      end

      unique case (mode_in)
         MODE_START: begin
            if (phase_ff == PHASE_LAST) begin
               phase_in       = 2'd0;
               time_in.hour   = HOUR_NOON;
               time_in.minute = 6'd0;
               lit_in         = 1'b1;
            end else begin
               phase_in = phase_ff + 2'd1;
               lit_in   = 1'b0;
            end
            if (any_pressed) begin
               mode_in = MODE_PEND;
            end
         end
         MODE_RUN: begin
            if (minute_due) begin
               count_in = count_inc - tpm_ff;
               time_in  = time_plus_minute;
               lit_in   = 1'b1;
            end
            if (phase_ff == PHASE_LAST) begin
               phase_in = 2'd0;
               lamp_in  = 1'b1;
            end else begin
               phase_in = phase_ff + 2'd1;
               lamp_in  = 1'b0;
            end
            if (any_pressed) begin
               mode_in = MODE_PEND;
            end
         end
         MODE_PEND: begin
            // Button zero wins and only returns to running mode.
            if (in_set_none_ff) begin
               time_in = roll_time(time_ff);
            end else if (in_minute_ff) begin
               time_in  = time_plus_minute;
               count_in = '0;
            end else if (in_hour_ff) begin
               time_in = time_plus_hour;
            end else begin
               time_in = roll_time(time_ff);
            end
            lit_in  = 1'b1;
            mode_in = MODE_RUN;
         end
         MODE_LOWP: begin
            if (in_power_ff) begin
               mode_in = MODE_RUN;
               lit_in  = 1'b1;
            end
            // Keep time without touching the lamp or the display.
            if (minute_due) begin
               count_in = count_inc - tpm_ff;
               time_in  = time_plus_minute;
            end
         end
         default: begin
            mode_in = mode_ff;
         end
      endcase
   end

   // Control and clock state
   always_ff @(posedge clock) begin
      if (reset) begin
         tpm_ff       <= TPM_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= MODE_START;
         count_ff     <= '0;
         time_ff      <= '{minute: 6'd0, hour: HOUR_NOON, pm: 1'b1};
         phase_ff     <= PHASE_INIT;
         lamp_ff      <= 1'b0;
         lit_ff       <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            tpm_ff <= csr_wr_data;
         end
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (advance) begin
            mode_ff  <= mode_in;
            count_ff <= count_in;
            time_ff  <= time_in;
            phase_ff <= phase_in;
            lamp_ff  <= lamp_in;
            lit_ff   <= lit_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_set_none_ff <= req_chan.set_none_pressed;
         in_minute_ff   <= req_chan.minute_pressed;
         in_hour_ff     <= req_chan.hour_pressed;
         in_power_ff    <= req_chan.power_good;
      end
      if (advance) begin
         out_time_ff <= time_in;
         out_lit_ff  <= lit_in;
         out_lamp_ff <= lamp_in;
         out_mode_ff <= mode_in;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.minute_value = out_time_ff.minute;
   assign rsp_chan.hour_value   = out_time_ff.hour;
   assign rsp_chan.pm_flag      = out_time_ff.pm;
   assign rsp_chan.display_lit  = out_lit_ff;
   assign rsp_chan.tick_lamp    = out_lamp_ff;
   assign rsp_chan.mode_now     = out_mode_ff;

endmodule
`default_nettype wire
